// ===== hw/rtl/mstc_pkg.sv =====
package mstc_pkg;

    // Default width of every count and total
    localparam int LEN_BITS_DEFAULT = 28;

    // Depth of the result queue; two words may enter in one cycle
    localparam int RESULT_DEPTH = 4;

    // Characters of the mismatch string
    localparam logic [7:0] CH_OPEN  = 8'h3E;  // '>'
    localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'
    localparam logic [7:0] CH_A     = 8'h41;  // 'A'
    localparam logic [7:0] CH_T     = 8'h54;  // 'T'
    localparam logic [3:0] DIGIT_MASK = 4'hF;

    // Operation kinds
    typedef enum logic [1:0] {
        KIND_MATCH = 2'd0,
        KIND_INS   = 2'd1,
        KIND_DEL   = 2'd2
    } kind_t;

endpackage

// ===== hw/rtl/mstc_if.sv =====
// Mismatch string channel: one character a word
interface md_if;
    logic       valid;
    logic       ready;
    logic [7:0] md_byte;
    logic       last;

    modport source (output valid, output md_byte, output last, input ready);
    modport sink   (input valid, input md_byte, input last, output ready);
endinterface

// Operation channel: one operation and/or record summary a word
interface cigar_if
    import mstc_pkg::*;
#(
    parameter int LENGTH_BITS = LEN_BITS_DEFAULT
);
    logic                          valid;
    logic                          ready;
    logic [1:0]                    op_code;
    logic [LENGTH_BITS-1:0]        op_length;
    logic                          op_present;
    logic                          end_of_record;
    logic [LENGTH_BITS-1:0]        edit_distance;
    logic signed [LENGTH_BITS:0]   length_difference;
    logic [LENGTH_BITS-1:0]        max_indel_total;

    modport source (
        output valid, output op_code, output op_length, output op_present,
        output end_of_record, output edit_distance, output length_difference,
        output max_indel_total, input ready
    );
    modport sink (
        input valid, input op_code, input op_length, input op_present,
        input end_of_record, input edit_distance, input length_difference,
        input max_indel_total, output ready
    );
endinterface

// ===== hw/rtl/mstc_core.sv =====
module mstc_core
    import mstc_pkg::*;
#(
    parameter int LENGTH_BITS = LEN_BITS_DEFAULT,
    parameter int RES_W       = 4 * LENGTH_BITS + 5
)(
    input  logic             clk,
    input  logic             rst_n,
    md_if.sink               md,
    input  logic             space,
    output logic [1:0]       push_count,
    output logic [RES_W-1:0] push_word0,
    output logic [RES_W-1:0] push_word1
);

    localparam int LB = LENGTH_BITS;
    localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};

    function automatic logic [LB-1:0] sat(input logic [LB+1:0] s);
        return (s > {2'b00, LEN_MAX}) ? LEN_MAX : s[LB-1:0];
    endfunction

    // Input register
    logic       in_valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       fire;

    // Parser state
    logic          in_indel_reg, in_indel_next;
    logic [LB-1:0] acc_reg, acc_next;
    logic          drop_reg, drop_next;
    logic [LB-1:0] run_reg, run_next;
    logic [LB-1:0] mis_reg, mis_next;
    kind_t         pkind_reg, pkind_next;
    logic [LB-1:0] plen_reg, plen_next;
    logic          pvalid_reg, pvalid_next;
    logic [LB-1:0] edit_reg, edit_next;
    logic [LB-1:0] del_reg, del_next;
    logic [LB-1:0] ins_reg, ins_next;

    assign fire     = in_valid_reg && space;
    assign md.ready = !in_valid_reg || fire;

    // Hold the accepted word until the queue has room for two results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (md.ready)
        begin
            in_valid_reg <= md.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (md.valid && md.ready)
        begin
            byte_reg <= md.md_byte;
            last_reg <= md.last;
        end
    end

    always_comb
    begin
        logic [7:0]    b;
        logic          is_digit;
        logic          is_letter;
        logic [LB+3:0] acc_x10;
        logic [LB-1:0] acc_dig;
        logic [LB-1:0] run_c;
        logic [LB-1:0] acc_c;
        logic [LB-1:0] mis_c;
        logic          close_en;
        logic          indel_close;
        logic [LB-1:0] edit_add;
        logic [LB-1:0] match_len;
        logic          push_en;
        kind_t         push_kind;
        logic [LB-1:0] push_len;
        logic          push_do;
        logic          emit0;
        logic          summary;
        logic [LB-1:0] fin_len;
        logic [1:0]    fin_code;
        logic [LB:0]   diff;
        logic [LB-1:0] maxi;
        logic [RES_W-1:0] r0;
        logic [RES_W-1:0] rf;

        b         = byte_reg;
        is_digit  = b inside {[CH_ZERO:CH_NINE]};
        is_letter = b inside {[CH_A:CH_T]};

        // Next decimal digit, saturated, unless digits are being dropped
        acc_x10 = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                + {{LB{1'b0}}, b[3:0] & DIGIT_MASK};
        if (drop_reg)
            acc_dig = acc_reg;
        else if (acc_x10 > {4'b0000, LEN_MAX})
            acc_dig = LEN_MAX;
        else
            acc_dig = acc_x10[LB-1:0];

        in_indel_next = in_indel_reg;
        drop_next     = drop_reg;
        run_c         = run_reg;
        acc_c         = acc_reg;
        mis_c         = mis_reg;
        close_en      = 1'b0;
        indel_close   = 1'b0;
        del_next      = del_reg;
        ins_next      = ins_reg;
        push_en       = 1'b0;
        push_kind     = KIND_MATCH;
        push_len      = '0;

        if (!in_indel_reg)
        begin
            if (b == CH_OPEN)
            begin
                close_en      = 1'b1;
                in_indel_next = 1'b1;
            end
            else if (is_letter)
            begin
                run_c     = sat({2'b00, run_reg} + {2'b00, acc_reg});
                acc_c     = '0;
                drop_next = 1'b0;
                mis_c     = sat({2'b00, mis_reg} + (LB+2)'(1));
            end
            else if (is_digit)
            begin
                acc_c = acc_dig;
            end
            else
            begin
                drop_next = 1'b1;
            end
            if (last_reg)
                close_en = 1'b1;
        end
        else
        begin
            if (b == CH_PLUS || b == CH_MINUS)
            begin
                indel_close   = 1'b1;
                push_en       = 1'b1;
                push_len      = acc_reg;
                in_indel_next = 1'b0;
                acc_c         = '0;
                drop_next     = 1'b0;
                if (b == CH_PLUS)
                begin
                    push_kind = KIND_DEL;
                    del_next  = sat({2'b00, del_reg} + {2'b00, acc_reg});
                end
                else
                begin
                    push_kind = KIND_INS;
                    ins_next  = sat({2'b00, ins_reg} + {2'b00, acc_reg});
                end
            end
            else if (is_digit)
            begin
                acc_c = acc_dig;
            end
            else
            begin
                drop_next = 1'b1;
            end
        end

        // Close the match run: digits, earlier runs and mismatches together
        match_len = sat({2'b00, run_c} + {2'b00, acc_c} + {2'b00, mis_c});
        if (indel_close)
            edit_add = acc_reg;
        else if (close_en)
            edit_add = mis_c;
        else
            edit_add = '0;
        edit_next = sat({2'b00, edit_reg} + {2'b00, edit_add});

        run_next = run_c;
        acc_next = acc_c;
        mis_next = mis_c;
        if (close_en)
        begin
            push_en   = 1'b1;
            push_kind = KIND_MATCH;
            push_len  = match_len;
            run_next  = '0;
            acc_next  = '0;
            mis_next  = '0;
            drop_next = 1'b0;
        end

        // Merge with the held operation or emit it and hold the new one
        push_do     = push_en && (push_len != '0);
        emit0       = push_do && pvalid_reg && (pkind_reg != push_kind);
        pkind_next  = pkind_reg;
        plen_next   = plen_reg;
        pvalid_next = pvalid_reg;
        if (push_do)
        begin
            if (pvalid_reg && pkind_reg == push_kind)
            begin
                plen_next = sat({2'b00, plen_reg} + {2'b00, push_len});
            end
            else
            begin
                pkind_next  = push_kind;
                plen_next   = push_len;
                pvalid_next = 1'b1;
            end
        end

        r0 = {pkind_reg, plen_reg, 1'b1, 1'b0, {LB{1'b0}}, {(LB+1){1'b0}},
              {LB{1'b0}}};

        // Record summary with the flushed operation
        summary  = last_reg;
        fin_code = pvalid_next ? pkind_next : KIND_MATCH;
        fin_len  = pvalid_next ? plen_next : '0;
        diff     = {1'b0, del_next} - {1'b0, ins_next};
        maxi     = (del_next > ins_next) ? del_next : ins_next;
        rf = {fin_code, fin_len, pvalid_next, 1'b1, edit_next, diff, maxi};

        push_word0 = emit0 ? r0 : rf;
        push_word1 = rf;
        push_count = 2'b00;
        if (fire)
            push_count = {1'b0, emit0} + {1'b0, summary};

        // End of record returns all state to reset
        if (summary)
        begin
            in_indel_next = 1'b0;
            acc_next      = '0;
            drop_next     = 1'b0;
            run_next      = '0;
            mis_next      = '0;
            pkind_next    = KIND_MATCH;
            plen_next     = '0;
            pvalid_next   = 1'b0;
            edit_next     = '0;
            del_next      = '0;
            ins_next      = '0;
        end
    end

    // Advance the parser state on each processed word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_indel_reg <= 1'b0;
            acc_reg      <= '0;
            drop_reg     <= 1'b0;
            run_reg      <= '0;
            mis_reg      <= '0;
            pkind_reg    <= KIND_MATCH;
            plen_reg     <= '0;
            pvalid_reg   <= 1'b0;
            edit_reg     <= '0;
            del_reg      <= '0;
            ins_reg      <= '0;
        end
        else if (fire)
        begin
            in_indel_reg <= in_indel_next;
            acc_reg      <= acc_next;
            drop_reg     <= drop_next;
            run_reg      <= run_next;
            mis_reg      <= mis_next;
            pkind_reg    <= pkind_next;
            plen_reg     <= plen_next;
            pvalid_reg   <= pvalid_next;
            edit_reg     <= edit_next;
            del_reg      <= del_next;
            ins_reg      <= ins_next;
        end
    end

endmodule

// ===== hw/rtl/mstc_queue.sv =====
module mstc_queue
    import mstc_pkg::*;
#(
    parameter int WIDTH = 4 * LEN_BITS_DEFAULT + 5,
    parameter int DEPTH = RESULT_DEPTH
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [1:0]       push_count,
    input  logic [WIDTH-1:0] push_word0,
    input  logic [WIDTH-1:0] push_word1,
    output logic             space,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_word
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] ROOM2     = CW'(DEPTH - 2);

    function automatic logic [PW-1:0] inc(input logic [PW-1:0] p);
        return (p == LAST_SLOT) ? '0 : p + PW'(1);
    endfunction

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_reg, wr_next;
    logic [PW-1:0]    rd_reg, rd_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             pop;
    logic [PW-1:0]    wr_plus1;

    assign out_valid = (count_reg != '0);
    assign out_word  = slot_reg[rd_reg];
    assign space     = (count_reg <= ROOM2);
    assign pop       = out_valid && out_ready;
    assign wr_plus1  = inc(wr_reg);

    always_comb
    begin
        wr_next = wr_reg;
        if (push_count == 2'd1)
            wr_next = wr_plus1;
        else if (push_count == 2'd2)
            wr_next = inc(wr_plus1);
        rd_next    = pop ? inc(rd_reg) : rd_reg;
        count_next = count_reg + CW'(push_count) - CW'(pop);
    end

    // Advance pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

    // Store up to two result words a cycle
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            slot_reg[wr_reg] <= push_word0;
        if (push_count == 2'd2)
            slot_reg[wr_plus1] <= push_word1;
    end

endmodule

// ===== hw/rtl/mismatch_string_to_cigar.sv =====
// Channel   Dir   Word contents
// md        in    md_byte[7:0], last
// cigar     out   op_code, op_length, op_present, end_of_record,
//                 edit_distance, length_difference, max_indel_total
//
// One character enters per cycle while md.ready is high; it waits in the input
// register until the queue has room, and its words are written to the result queue.
// A character gives at most two words; characters that each gave two words
// would be limited by the single output port, which passes one word at a time.
// The result queue holds four words; md.ready drops while fewer than two
// slots are free and the input register is full.
// rst_n clears the parser state and the queue at once.
module mismatch_string_to_cigar
    import mstc_pkg::*;
#(
    parameter int LENGTH_BITS = LEN_BITS_DEFAULT
)(
    input  logic     clk,
    input  logic     rst_n,
    md_if.sink       md,
    cigar_if.source  cigar
);

    localparam int LB    = LENGTH_BITS;
    localparam int RES_W = 4 * LB + 5;

    logic             space;
    logic [1:0]       push_count;
    logic [RES_W-1:0] push_word0;
    logic [RES_W-1:0] push_word1;
    logic [RES_W-1:0] out_word;

    mstc_core #(
        .LENGTH_BITS (LB),
        .RES_W       (RES_W)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .md         (md),
        .space      (space),
        .push_count (push_count),
        .push_word0 (push_word0),
        .push_word1 (push_word1)
    );

    mstc_queue #(
        .WIDTH (RES_W),
        .DEPTH (RESULT_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_word0 (push_word0),
        .push_word1 (push_word1),
        .space      (space),
        .out_valid  (cigar.valid),
        .out_ready  (cigar.ready),
        .out_word   (out_word)
    );

    // Split the queued word into the output fields
    assign {cigar.op_code, cigar.op_length, cigar.op_present, cigar.end_of_record,
            cigar.edit_distance, cigar.length_difference,
            cigar.max_indel_total} = out_word;

endmodule

// ===== sim/mismatch_string_to_cigar_test.sv =====
module mismatch_string_to_cigar_test;
    import mstc_pkg::*;

    localparam int LB = LEN_BITS_DEFAULT;
    localparam logic [LB-1:0] LEN_MAX = {LB{1'b1}};
    localparam int HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES = 20;
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASE_CHARS = 150;

    typedef struct {
        logic [7:0] ch;
        logic       eor;
    } md_char_t;

    typedef struct {
        kind_t              op_code;
        logic [LB-1:0]      op_length;
        logic               op_present;
        logic               end_of_record;
        logic [LB-1:0]      edit_distance;
        logic signed [LB:0] length_difference;
        logic [LB-1:0]      max_indel_total;
    } cigar_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic       send_valid = 1'b0;
    logic [7:0] send_char = 8'd0;
    logic       send_last = 1'b0;
    logic       take_ready = 1'b0;

    md_if md();
    cigar_if #(.LENGTH_BITS(LB)) cigar();

    assign md.valid = send_valid;
    assign md.md_byte = send_char;
    assign md.last = send_last;
    assign cigar.ready = take_ready;

    mismatch_string_to_cigar #(.LENGTH_BITS(LB)) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .md    (md),
        .cigar (cigar)
    );

    // Traffic control, set at the falling edge by the sequence below
    int send_idle_pct = 0;
    int stall_pct = 0;
    logic hold_req = 1'b0;
    int hold_left = 0;

    md_char_t pending_chars[$];
    logic [7:0] rec_chars[$];
    cigar_word_t expected_words[$];
    md_char_t head_char;
    cigar_word_t want;
    int mismatches = 0;
    int cycle_count = 0;

    // Parser state of the predictor
    logic          indel_open = 1'b0;
    logic [LB-1:0] count_acc = '0;
    logic          skip_digits = 1'b0;
    logic [LB-1:0] matched_bases = '0;
    logic [LB-1:0] mismatched_bases = '0;
    kind_t         held_kind = KIND_MATCH;
    logic [LB-1:0] held_length = '0;
    logic          held_valid = 1'b0;
    logic [LB-1:0] edits = '0;
    logic [LB-1:0] del_bases = '0;
    logic [LB-1:0] ins_bases = '0;

    always
    begin
        #2;
        clk = 1'b1;
        #2;
        clk = 1'b0;
    end

    function automatic logic [LB-1:0] sat_sum(logic [LB-1:0] a, logic [LB-1:0] b);
        logic [LB:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s > {1'b0, LEN_MAX}) ? LEN_MAX : s[LB-1:0];
    endfunction

    function automatic void add_digit(logic [3:0] d);
        logic [63:0] v;
        if (skip_digits)
            return;
        v = 64'(count_acc) * 64'd10 + 64'(d);
        count_acc = (v > 64'(LEN_MAX)) ? LEN_MAX : v[LB-1:0];
    endfunction

    function automatic void emit_word(kind_t kind, logic [LB-1:0] len, logic present,
                                      logic eor);
        cigar_word_t w;
        w.op_code = kind;
        w.op_length = len;
        w.op_present = present;
        w.end_of_record = eor;
        w.edit_distance = '0;
        w.length_difference = '0;
        w.max_indel_total = '0;
        if (eor)
        begin
            w.edit_distance = edits;
            w.length_difference = {1'b0, del_bases} - {1'b0, ins_bases};
            w.max_indel_total = (del_bases > ins_bases) ? del_bases : ins_bases;
        end
        expected_words.push_back(w);
    endfunction

    // Merge with the held op, or release it and hold the new one
    function automatic void queue_op(kind_t kind, logic [LB-1:0] len);
        if (len == 0)
            return;
        if (held_valid && held_kind == kind)
        begin
            held_length = sat_sum(held_length, len);
            return;
        end
        if (held_valid)
            emit_word(held_kind, held_length, 1'b1, 1'b0);
        held_kind = kind;
        held_length = len;
        held_valid = 1'b1;
    endfunction

    function automatic void close_match_run();
        logic [LB-1:0] len;
        len = sat_sum(sat_sum(matched_bases, count_acc), mismatched_bases);
        edits = sat_sum(edits, mismatched_bases);
        queue_op(KIND_MATCH, len);
        matched_bases = '0;
        count_acc = '0;
        mismatched_bases = '0;
        skip_digits = 1'b0;
    endfunction

    function automatic void clear_parser();
        indel_open = 1'b0;
        count_acc = '0;
        skip_digits = 1'b0;
        matched_bases = '0;
        mismatched_bases = '0;
        held_kind = KIND_MATCH;
        held_length = '0;
        held_valid = 1'b0;
        edits = '0;
        del_bases = '0;
        ins_bases = '0;
    endfunction

    // Advance the parser by one accepted character, queueing its words
    function automatic void parse_md_char(logic [7:0] ch, logic eor);
        logic is_digit;
        is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
        if (!indel_open)
        begin
            if (ch == CH_OPEN)
            begin
                close_match_run();
                indel_open = 1'b1;
            end
            else if (ch >= CH_A && ch <= CH_T)
            begin
                matched_bases = sat_sum(matched_bases, count_acc);
                count_acc = '0;
                skip_digits = 1'b0;
                mismatched_bases = sat_sum(mismatched_bases, LB'(1));
            end
            else if (is_digit)
                add_digit(ch[3:0] & DIGIT_MASK);
            else
                skip_digits = 1'b1;
        end
        else
        begin
            if (ch == CH_PLUS || ch == CH_MINUS)
            begin
                edits = sat_sum(edits, count_acc);
                if (ch == CH_PLUS)
                begin
                    del_bases = sat_sum(del_bases, count_acc);
                    queue_op(KIND_DEL, count_acc);
                end
                else
                begin
                    ins_bases = sat_sum(ins_bases, count_acc);
                    queue_op(KIND_INS, count_acc);
                end
                indel_open = 1'b0;
                count_acc = '0;
                skip_digits = 1'b0;
            end
            else if (is_digit)
                add_digit(ch[3:0] & DIGIT_MASK);
            else
                skip_digits = 1'b1;
        end
        if (eor)
        begin
            if (!indel_open)
                close_match_run();
            if (held_valid)
                emit_word(held_kind, held_length, 1'b1, 1'b1);
            else
                emit_word(KIND_MATCH, '0, 1'b0, 1'b1);
            clear_parser();
        end
    endfunction

    function automatic void check_field(string name, logic signed [63:0] exp_val,
                                        logic signed [63:0] act_val);
        if (act_val !== exp_val)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            mismatches++;
        end
    endfunction

    // Stimulus building: characters gather in rec_chars, then move as one record
    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            rec_chars.push_back(s[i]);
    endfunction

    function automatic void commit_record();
        md_char_t c;
        foreach (rec_chars[i])
        begin
            c.ch = rec_chars[i];
            c.eor = (i == rec_chars.size() - 1);
            pending_chars.push_back(c);
        end
        rec_chars.delete();
    endfunction

    // Decimal count; now and then long enough to saturate
    function automatic void add_count();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 8)
            n = $urandom_range(9, 11);
        else if (pick < 15)
            n = 0;
        else
            n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++)
            rec_chars.push_back((pick < 8) ? CH_NINE : CH_ZERO + 8'($urandom_range(9)));
    endfunction

    function automatic void build_record();
        int tokens;
        int pick;
        tokens = $urandom_range(1, 6);
        for (int t = 0; t < tokens; t++)
        begin
            pick = $urandom_range(99);
            if (pick < 30)
                add_count();
            else if (pick < 55)
                rec_chars.push_back(CH_A + 8'($urandom_range(19)));
            else if (pick < 85)
            begin
                rec_chars.push_back(CH_OPEN);
                add_count();
                rec_chars.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
            end
            else if (pick < 92)
                rec_chars.push_back(8'($urandom_range(255)));
            else if (pick < 96)
            begin
                // open an indel and leave it; may run into the record end
                rec_chars.push_back(CH_OPEN);
                add_count();
            end
            else
            begin
                // stray byte inside an indel count
                rec_chars.push_back(CH_OPEN);
                add_count();
                rec_chars.push_back(8'($urandom_range(255)));
                add_count();
                rec_chars.push_back($urandom_range(1) ? CH_PLUS : CH_MINUS);
            end
        end
        if (rec_chars.size() == 0)
            rec_chars.push_back(CH_ZERO);
    endfunction

    task automatic queue_random_chars(int n_chars);
        int made;
        made = 0;
        while (made < n_chars)
        begin
            build_record();
            made += rec_chars.size();
            commit_record();
        end
    endtask

    // Wait until every pending character is sent and every expected word has come back
    task automatic wait_drained();
        while (pending_chars.size() != 0 || send_valid || expected_words.size() != 0)
            @(negedge clk);
    endtask

    // Driver: offer the next pending character, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            send_valid <= 1'b0;
            send_char <= 8'd0;
            send_last <= 1'b0;
        end
        else
        begin
            if (send_valid && md.ready)
                parse_md_char(send_char, send_last);
            if (!send_valid || md.ready)
            begin
                if (pending_chars.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    head_char = pending_chars.pop_front();
                    send_valid <= 1'b1;
                    send_char <= head_char.ch;
                    send_last <= head_char.eor;
                end
                else
                    send_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each accepted word, then set ready for the next cycle
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            take_ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (cigar.valid && cigar.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("unexpected word: op_code %0d op_length %0d end_of_record %0d",
                           cigar.op_code, cigar.op_length, cigar.end_of_record);
                    mismatches++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("op_code", want.op_code, cigar.op_code);
                    check_field("op_length", want.op_length, cigar.op_length);
                    check_field("op_present", want.op_present, cigar.op_present);
                    check_field("end_of_record", want.end_of_record, cigar.end_of_record);
                    check_field("edit_distance", want.edit_distance, cigar.edit_distance);
                    check_field("length_difference", want.length_difference,
                                cigar.length_difference);
                    check_field("max_indel_total", want.max_indel_total,
                                cigar.max_indel_total);
                end
            end
            if (hold_left != 0)
            begin
                take_ready <= 1'b0;
                hold_left <= hold_left - 1;
            end
            else if (hold_req)
            begin
                take_ready <= 1'b0;
                hold_left <= HOLD_CYCLES;
                hold_req <= 1'b0;
            end
            else
                take_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed records: match, deletion, insertion, a letter at the end
        add_text("12A>3+>4-T");
        commit_record();
        // Stray byte in a match run, repeated open inside an indel, stray last byte
        add_text("C#5>2>1+");
        rec_chars.push_back(8'hFF);
        commit_record();
        // Nothing but a zero byte: summary only
        rec_chars.push_back(8'h00);
        commit_record();
        // Indel never closed
        add_text(">5");
        commit_record();
        wait_drained();

        // Random phases: none (with one long receiver hold in the first), sender idle, receiver stalls, both
        for (int phase = 0; phase < 4; phase++)
        begin
            @(negedge clk);
            send_idle_pct = (phase == 1) ? 48 : (phase == 3) ? 20 : 0;
            stall_pct = (phase == 2) ? 48 : (phase == 3) ? 20 : 0;
            queue_random_chars(PHASE_CHARS);
            if (phase == 0)
                hold_req = 1'b1;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
